// ===== hw/rtl/rmfr_pkg.sv =====
// shared types and constants for the repeated marker frame receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rmfr_pkg;

  // default payload store depth
  localparam int unsigned BufferDepthDefault = 64;

  // fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RptW   = 4;
  localparam int unsigned LenW   = 7;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // register reset values
  localparam logic [ByteW-1:0] HeaderReset = 8'hAA;
  localparam logic [ByteW-1:0] FooterReset = 8'h55;
  localparam logic [RptW-1:0]  RepeatReset = 4'd3;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_FOOTER = 2'd1,
    REG_REPEAT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic [ByteW-1:0] footer_byte;
    logic [RptW-1:0]  repeat_count;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // process the input beat
    logic rd;     // read store at the replay index
    logic load;   // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done;  // current input beat completes a frame
    logic emit_last;   // replay index is at the final result
    logic out_full;    // output register holds a beat that is not taken
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmfr_ctrl.sv =====
// controller state machine: input acceptance and frame replay sequencing
// depends on rmfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmfr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  rmfr_pkg::status_t sts_i,
  output rmfr_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.frame_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        // wait for the output register to free up
        if (!sts_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rmfr_datapath.sv =====
// datapath: marker counters, payload store, replay index and output register
// depends on rmfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmfr_datapath #(
  parameter int unsigned BufferDepth = rmfr_pkg::BufferDepthDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rmfr_pkg::cfg_t               cfg_i,
  input  rmfr_pkg::cmd_t               cmd_i,
  output rmfr_pkg::status_t            sts_o,
  input  wire [rmfr_pkg::ByteW-1:0]    rx_byte_i,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [rmfr_pkg::ByteW-1:0]   frame_byte_o,
  output logic [rmfr_pkg::LenW-1:0]    frame_length_o,
  output logic                         is_last_o,
  output logic                         overflowed_o
);

  localparam int unsigned CntW  = $clog2(BufferDepth + 1);
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  localparam int unsigned RptW  = rmfr_pkg::RptW;
  localparam int unsigned ByteW = rmfr_pkg::ByteW;
  localparam int unsigned LenW  = rmfr_pkg::LenW;

  logic [RptW-1:0] header_seen_q, header_seen_d;
  logic [RptW-1:0] footer_seen_q, footer_seen_d;
  logic            armed_q, armed_d;
  logic [CntW-1:0] stored_count_q, stored_count_d;
  logic            overflow_q, overflow_d;

  logic [CntW-1:0] emit_len_q, emit_len_d;
  logic            emit_ovf_q, emit_ovf_d;
  logic [CntW-1:0] emit_idx_q, emit_idx_d;

  logic [ByteW-1:0] store_mem [BufferDepth];
  logic [ByteW-1:0] rd_data_q;

  logic                    out_valid_q;
  logic [ByteW-1:0]        out_byte_q;
  logic [LenW-1:0]         out_len_q;
  logic                    out_last_q;
  logic                    out_ovf_q;

  logic            is_hdr, is_ftr;
  logic [RptW-1:0] hs_next, fs_inc;
  logic            has_room;
  logic            store_we;

  assign is_hdr   = (rx_byte_i == cfg_i.header_byte);
  assign is_ftr   = (rx_byte_i == cfg_i.footer_byte);
  assign hs_next  = (header_seen_q < cfg_i.repeat_count) ? header_seen_q + RptW'(1)
                                                         : header_seen_q;
  assign fs_inc   = footer_seen_q + RptW'(1);
  assign has_room = (stored_count_q < CntW'(BufferDepth));
  assign store_we = cmd_i.take && !is_hdr && armed_q && !is_ftr && has_room;

  assign sts_o.frame_done = !is_hdr && armed_q && is_ftr && (fs_inc == cfg_i.repeat_count);
  assign sts_o.emit_last  = (emit_len_q == '0) || ((emit_idx_q + CntW'(1)) == emit_len_q);
  assign sts_o.out_full   = out_valid_q && !out_ready_i;

  always_comb begin
    header_seen_d  = header_seen_q;
    footer_seen_d  = footer_seen_q;
    armed_d        = armed_q;
    stored_count_d = stored_count_q;
    overflow_d     = overflow_q;
    emit_len_d     = emit_len_q;
    emit_ovf_d     = emit_ovf_q;
    emit_idx_d     = emit_idx_q;
    if (cmd_i.take) begin
      priority if (is_hdr) begin
        footer_seen_d = '0;
        header_seen_d = hs_next;
        if (armed_q) begin
          stored_count_d = '0;
          overflow_d     = 1'b0;
        end
        armed_d = (hs_next == cfg_i.repeat_count);
      end else if (armed_q && is_ftr) begin
        header_seen_d = '0;
        if (fs_inc == cfg_i.repeat_count) begin
          // latch the frame for replay, then empty the store
          emit_len_d     = stored_count_q;
          emit_ovf_d     = overflow_q;
          emit_idx_d     = '0;
          footer_seen_d  = '0;
          armed_d        = 1'b0;
          stored_count_d = '0;
          overflow_d     = 1'b0;
        end else begin
          footer_seen_d = fs_inc;
        end
      end else if (armed_q) begin
        if (has_room) begin
          stored_count_d = stored_count_q + CntW'(1);
        end else begin
          overflow_d = 1'b1;
        end
      end else begin
        // disarmed: byte ignored
        armed_d = armed_q;
      end
    end
    if (cmd_i.load) begin
      emit_idx_d = emit_idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_seen_q  <= '0;
      footer_seen_q  <= '0;
      armed_q        <= 1'b0;
      stored_count_q <= '0;
      overflow_q     <= 1'b0;
      emit_len_q     <= '0;
      emit_ovf_q     <= 1'b0;
      emit_idx_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      header_seen_q  <= header_seen_d;
      footer_seen_q  <= footer_seen_d;
      armed_q        <= armed_d;
      stored_count_q <= stored_count_d;
      overflow_q     <= overflow_d;
      emit_len_q     <= emit_len_d;
      emit_ovf_q     <= emit_ovf_d;
      emit_idx_q     <= emit_idx_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[stored_count_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= store_mem[emit_idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= (emit_len_q == '0) ? '0 : rd_data_q;
      out_len_q  <= LenW'(emit_len_q);
      out_last_q <= sts_o.emit_last;
      out_ovf_q  <= emit_ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = out_byte_q;
  assign frame_length_o = out_len_q;
  assign is_last_o      = out_last_q;
  assign overflowed_o   = out_ovf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/repeated_marker_frame_receiver.sv =====
// top level: apb register block, controller and datapath of the frame receiver
// depends on rmfr_pkg, rmfr_ctrl, rmfr_datapath
//
//   port group   dir   beat content
//   s_axis       in    tdata[7:0] rx_byte
//   m_axis       out   tdata[7:0] frame_byte, [14:8] frame_length; tlast is_last;
//                      tuser overflowed
//   apb          in    0x0 header_byte, 0x4 footer_byte, 0x8 repeat_count
//
// an input beat is taken whenever no frame replays; header, footer and payload bytes alike
// a completed frame replays one result at a time (store read, then output load),
// since the payload store has a single read port; no input is taken meanwhile
// a full output register that is not taken holds the replay in place
// reset clears counters and control; the store needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module repeated_marker_frame_receiver #(
  parameter int unsigned BufferDepth = rmfr_pkg::BufferDepthDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // rx_byte [7:0]
  input  wire  [7:0]                    s_axis_tdata,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // frame_byte [7:0], frame_length [14:8], zero [15]
  output logic [15:0]                   m_axis_tdata,
  // overflowed [0]
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [rmfr_pkg::PaddrW-1:0]   paddr,
  input  wire  [rmfr_pkg::PdataW-1:0]   pwdata,
  output logic [rmfr_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  rmfr_pkg::cfg_t    cfg_q;
  rmfr_pkg::cmd_t    cmd;
  rmfr_pkg::status_t sts;
  rmfr_pkg::reg_idx_e reg_idx;
  logic               cfg_we;

  logic [rmfr_pkg::ByteW-1:0] frame_byte;
  logic [rmfr_pkg::LenW-1:0]  frame_length;

  assign pready  = 1'b1;
  assign reg_idx = rmfr_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte  <= rmfr_pkg::HeaderReset;
      cfg_q.footer_byte  <= rmfr_pkg::FooterReset;
      cfg_q.repeat_count <= rmfr_pkg::RepeatReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        rmfr_pkg::REG_HEADER: cfg_q.header_byte  <= pwdata[7:0];
        rmfr_pkg::REG_FOOTER: cfg_q.footer_byte  <= pwdata[7:0];
        rmfr_pkg::REG_REPEAT: cfg_q.repeat_count <= pwdata[3:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rmfr_pkg::REG_HEADER: prdata = {24'd0, cfg_q.header_byte};
      rmfr_pkg::REG_FOOTER: prdata = {24'd0, cfg_q.footer_byte};
      rmfr_pkg::REG_REPEAT: prdata = {28'd0, cfg_q.repeat_count};
      default:              prdata = '0;
    endcase
  end

  rmfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmfr_datapath #(
    .BufferDepth (BufferDepth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rx_byte_i      (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .frame_byte_o   (frame_byte),
    .frame_length_o (frame_length),
    .is_last_o      (m_axis_tlast),
    .overflowed_o   (m_axis_tuser[0])
  );

  assign m_axis_tdata = {1'b0, frame_length, frame_byte};

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for repeated_marker_frame_receiver
// depends on rmfr_pkg and the block's rtl; a built-in frame predictor checks every output beat
`timescale 1ns / 1ps

module tb_top;

  localparam int StoreDepth = 64;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 4;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] len;
    logic       last;
    logic       ovf;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    frame_beat_t beat;
  } drive_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [rmfr_pkg::PaddrW-1:0] paddr  = '0;
  logic [rmfr_pkg::PdataW-1:0] pwdata = '0;
  logic [rmfr_pkg::PdataW-1:0] prdata;
  logic        pready;

  // predictor copy of registers and receiver state
  logic [7:0] hdr_byte = rmfr_pkg::HeaderReset;
  logic [7:0] ftr_byte = rmfr_pkg::FooterReset;
  logic [3:0] rpt      = rmfr_pkg::RepeatReset;
  logic [3:0] hdr_seen = '0;
  logic [3:0] ftr_seen = '0;
  logic       armed    = 1'b0;
  logic [6:0] fill     = '0;
  logic       ovf_mark = 1'b0;
  logic [7:0] payload [StoreDepth];

  frame_beat_t pending_frame_beats [$];
  int fails       = 0;
  int sent_items  = 0;
  int cycle_count = 0;
  int tx_burst    = 0;
  int rx_burst    = 0;

  repeated_marker_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("repeated_marker_frame_receiver verification failed");
      $finish;
    end
  end

  function automatic void take_rx_byte(input logic [7:0] b);
    frame_beat_t beat;
    int n;
    int k;
    if (b == hdr_byte) begin
      ftr_seen = '0;
      if (hdr_seen < rpt) hdr_seen = hdr_seen + 4'd1;
      if (armed) begin
        fill     = '0;
        ovf_mark = 1'b0;
      end
      armed = (hdr_seen == rpt);
      return;
    end
    if (!armed) return;
    if (b == ftr_byte) begin
      hdr_seen = '0;
      ftr_seen = ftr_seen + 4'd1;
      if (ftr_seen != rpt) return;
      n = fill;
      if (n == 0) begin
        beat = '{data: 8'h00, len: 7'd0, last: 1'b1, ovf: ovf_mark};
        pending_frame_beats.push_back(beat);
      end else begin
        for (k = 0; k < n; k++) begin
          beat.data = payload[k];
          beat.len  = n[6:0];
          beat.last = (k == n - 1);
          beat.ovf  = ovf_mark;
          pending_frame_beats.push_back(beat);
        end
      end
      ftr_seen = '0;
      armed    = 1'b0;
      fill     = '0;
      ovf_mark = 1'b0;
    end else if (fill < StoreDepth) begin
      payload[fill] = b;
      fill = fill + 7'd1;
    end else begin
      ovf_mark = 1'b1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(8, 30);
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    take_rx_byte(b);
    sent_items++;
  endtask

  // hold the sender until every predicted beat has drained
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_frame_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input rmfr_pkg::reg_idx_e idx,
                           input logic [rmfr_pkg::PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rmfr_pkg::REG_HEADER: hdr_byte = value[7:0];
      rmfr_pkg::REG_FOOTER: ftr_byte = value[7:0];
      rmfr_pkg::REG_REPEAT: rpt      = value[3:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    do b = 8'($urandom); while (b == hdr_byte || b == ftr_byte);
    return b;
  endfunction

  task automatic send_frame(input int n_pay, input bit broken);
    int n_hdr;
    int n_ftr;
    n_hdr = rpt + $urandom_range(0, 1);
    repeat (n_hdr) send_byte(hdr_byte);
    repeat (n_pay) begin
      // a lone footer inside the payload leaves a partial footer run
      if (rpt > 1 && $urandom_range(0, 15) == 0) send_byte(ftr_byte);
      send_byte(pick_payload());
    end
    n_ftr = broken ? $urandom_range(0, rpt - 1) : rpt;
    repeat (n_ftr) send_byte(ftr_byte);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 2))
        0:       send_byte(hdr_byte);
        1:       send_byte(ftr_byte);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // output side: random stalls, each beat checked against the oldest prediction
  initial begin
    int stall;
    frame_beat_t want;
    @(posedge rst_ni);
    forever begin
      if (rx_burst > 0) begin
        stall = 0;
        rx_burst--;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_burst = $urandom_range(8, 30);
        stall = $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_frame_beats.size() == 0) begin
        $error("frame beat with none expected: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
        fails++;
      end else begin
        want = pending_frame_beats.pop_front();
        if (m_axis_tdata[7:0] !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, m_axis_tdata[7:0]);
          fails++;
        end
        if (m_axis_tdata[14:8] !== want.len) begin
          $error("frame_length: expected %0d, got %0d", want.len, m_axis_tdata[14:8]);
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, m_axis_tlast);
          fails++;
        end
        if (m_axis_tuser[0] !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, m_axis_tuser[0]);
          fails++;
        end
      end
    end
  end

  drive_row_t directed_rows [19] = '{
    '{8'h55, 1'b0, '0},   // footer while disarmed is ignored
    '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'hAA, 1'b0, '0},   // armed
    '{8'h55, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h55, 1'b1, '{data: 8'h00, len: 7'd0, last: 1'b1, ovf: 1'b0}},  // empty frame
    '{8'hAA, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hAA, 1'b0, '0},   // header while armed drops the stored bytes
    '{8'h7F, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h80, 1'b0, '0},   // payload between footers
    '{8'h55, 1'b0, '0},
    '{8'h55, 1'b0, '0}
  };

  initial begin
    int i;
    int ph;
    int sent0;
    int frame_no;
    int n_pay;
    int n0;
    int pick;
    rmfr_pkg::cfg_t phase_cfg [6];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 19; i++) begin
      n0 = pending_frame_beats.size();
      send_byte(directed_rows[i].rx);
      if (directed_rows[i].typed) begin
        while (pending_frame_beats.size() > n0) void'(pending_frame_beats.pop_back());
        pending_frame_beats.push_back(directed_rows[i].beat);
      end
    end

    phase_cfg[0] = '{header_byte: 8'h00, footer_byte: 8'hFF, repeat_count: 4'd1};
    // single markers with a header count of at most one left over: the first frame overruns
    phase_cfg[1] = '{header_byte: 8'hAA, footer_byte: 8'h55, repeat_count: 4'd1};
    phase_cfg[2] = '{header_byte: 8'hFF, footer_byte: 8'h00, repeat_count: 4'd15};
    // repeat count dropped below a header count left from the previous phase
    phase_cfg[3].header_byte  = 8'($urandom);
    phase_cfg[3].footer_byte  = phase_cfg[3].header_byte ^ 8'($urandom_range(1, 255));
    phase_cfg[3].repeat_count = 4'd1;
    // header and footer share one value: the header test wins
    phase_cfg[4].header_byte  = 8'($urandom);
    phase_cfg[4].footer_byte  = phase_cfg[4].header_byte;
    phase_cfg[4].repeat_count = 4'($urandom_range(1, 4));
    phase_cfg[5].header_byte  = 8'($urandom);
    phase_cfg[5].footer_byte  = phase_cfg[5].header_byte ^ 8'($urandom_range(1, 255));
    phase_cfg[5].repeat_count = 4'($urandom_range(1, 15));

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(rmfr_pkg::REG_HEADER, rmfr_pkg::PdataW'(phase_cfg[ph].header_byte));
      write_reg(rmfr_pkg::REG_FOOTER, rmfr_pkg::PdataW'(phase_cfg[ph].footer_byte));
      write_reg(rmfr_pkg::REG_REPEAT, rmfr_pkg::PdataW'(phase_cfg[ph].repeat_count));
      sent0    = sent_items;
      frame_no = 0;
      while (sent_items - sent0 < PhaseItems) begin
        // a frame that fills the store and then drops one byte
        if (ph == 1 && frame_no == 0)       n_pay = StoreDepth + 1;
        else if ($urandom_range(0, 5) == 0) n_pay = 0;
        else                                n_pay = $urandom_range(1, 8);
        pick = (ph == 1 && frame_no == 0) ? 0 : $urandom_range(0, 9);
        if (pick < 7)       send_frame(n_pay, 1'b0);
        else if (pick == 7) send_frame(n_pay, 1'b1);
        else                send_noise();
        frame_no++;
        if ($urandom_range(0, 15) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("repeated_marker_frame_receiver verification clean");
    end else begin
      $display("repeated_marker_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
